@@ rtl/core/skf_pkg.sv @@
`timescale 1ns / 1ps

package skf_pkg;

   // field and datapath widths
   localparam int DATA_W      = 32;   // sample, estimate, covariance, noise terms
   localparam int SCALE_W     = 16;   // measurement gain h, unsigned Q0.16
   localparam int GAIN_W      = 18;   // kalman gain, unsigned Q2.16
   localparam int HP_W        = 48;   // h * prior
   localparam int DEN_W       = 49;   // gain denominator
   localparam int INNOV_W     = 34;   // sample - h * estimate
   localparam int CORR_W      = 36;   // gain * innovation, scaled back
   localparam int FAC_W       = 33;   // 1 - gain * h, Q1.32
   localparam int GH_W        = 34;   // gain * h, Q2.32

   // shift-add multiplier
   localparam int MCAND_W     = 49;
   localparam int MPLIER_W    = 32;
   localparam int ACC_HI_W    = MCAND_W + 1;
   localparam int MUL_CNT_W   = 6;

   // restoring divider
   localparam int REM_W       = DEN_W;
   localparam int DIV_CNT_W   = 5;

   // multiplier bit counts per product
   localparam logic [MUL_CNT_W-1:0] MUL_LEN_SCALE = MUL_CNT_W'(SCALE_W);
   localparam logic [MUL_CNT_W-1:0] MUL_LEN_GAIN  = MUL_CNT_W'(GAIN_W);
   localparam logic [MUL_CNT_W-1:0] MUL_LEN_FULL  = MUL_CNT_W'(MPLIER_W);

   // configuration registers
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASURE_NOISE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASURE_SCALE = 2'd2;

   localparam logic [DATA_W-1:0]  PROCESS_NOISE_RST = 32'd13107;
   localparam logic [DATA_W-1:0]  MEASURE_NOISE_RST = 32'd6554;
   localparam logic [SCALE_W-1:0] MEASURE_SCALE_RST = 16'd62259;
   localparam logic [DATA_W-1:0]  EST_VALUE_RST     = 32'd655;
   localparam logic [DATA_W-1:0]  EST_COV_RST       = 32'd655;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_HX,
      ST_MUL_HP,
      ST_MUL_HHP,
      ST_DIV_GAIN,
      ST_MUL_CORR,
      ST_MUL_GH,
      ST_MUL_COV,
      ST_RESULT
   } skf_state_type;

   typedef struct packed {
      logic                 start;
      logic [MCAND_W-1:0]   mcand;    // two's complement
      logic [MPLIER_W-1:0]  mplier;   // unsigned
      logic [MUL_CNT_W-1:0] nbits;
   } skf_mul_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [ACC_HI_W-1:0] hi;
      logic [MPLIER_W-1:0] lo;
   } skf_mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic [HP_W-1:0]  hp;
      logic [DEN_W-1:0] den;
   } skf_div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [GAIN_W-1:0] gain;
   } skf_div_rsp_type;

endpackage

@@ rtl/core/skf_if.sv @@
`timescale 1ns / 1ps

interface skf_req_if import skf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface skf_rsp_if import skf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] estimate;

   modport source (output valid, output estimate, input ready);
   modport sink   (input valid, input estimate, output ready);
endinterface

@@ rtl/core/scalar_kalman_filter_core.sv @@
// one item in flight at a time; each item runs through the shared shift-add multiplier
//   (six products of 16, 16, 16, 18, 16 and 32 bits) and the 18-step divider
// a finished estimate waits in the output register while the next sample is taken
// reset (synchronous, active high) loads the default noise terms and h, sets the
//   estimate and covariance to 0.01 and empties the output register
`timescale 1ns / 1ps

module scalar_kalman_filter_core import skf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   skf_req_if.sink                req_bus,
   skf_rsp_if.source              rsp_bus
);

   localparam logic [DATA_W-1:0] EST_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] EST_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // configuration
   logic [DATA_W-1:0]  process_noise_ff;
   logic [DATA_W-1:0]  measure_noise_ff;
   logic [SCALE_W-1:0] measure_scale_ff;

   // filter state
   logic [DATA_W-1:0]  est_ff, est_in;
   logic [DATA_W-1:0]  cov_ff, cov_in;

   // per-item working registers
   skf_state_type      state_ff, state_in;
   logic [DATA_W-1:0]  sample_ff, sample_in;
   logic [DATA_W-1:0]  prior_ff, prior_in;
   logic [INNOV_W-1:0] innov_ff, innov_in;
   logic [HP_W-1:0]    hp_ff, hp_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;

   // output register
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff;
   logic               rsp_load;

   skf_mul_req_type    mul_req;
   skf_mul_rsp_type    mul_rsp;
   skf_div_req_type    div_req;
   skf_div_rsp_type    div_rsp;

   // datapath views
   logic [DATA_W:0]    prior_sum;
   logic [DATA_W-1:0]  prior_sat;
   logic [HP_W-1:0]    hp_w;
   logic [DEN_W-1:0]   den_w;
   logic [DATA_W:0]    hx_w;
   logic [INNOV_W-1:0] innov_w;
   logic [CORR_W-1:0]  corr_w;
   logic [DATA_W+4:0]  est_sum;
   logic [DATA_W-1:0]  est_sat;
   logic [GH_W-1:0]    gh_w;
   logic [FAC_W-1:0]   fac_w;

   skf_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   skf_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // prior covariance, saturated at the unsigned limit
   assign prior_sum = {1'b0, cov_ff} + {1'b0, process_noise_ff};
   assign prior_sat = prior_sum[DATA_W] ? '1 : prior_sum[DATA_W-1:0];

   // product slices: a product of n multiplier bits sits in {hi, lo[31 -: n]}
   assign hp_w    = {mul_rsp.hi[DATA_W-1:0], mul_rsp.lo[MPLIER_W-1 -: SCALE_W]};
   assign den_w   = {1'b0, mul_rsp.hi[HP_W-1:0]}
                  + {1'b0, measure_noise_ff, {SCALE_W{1'b0}}};
   assign hx_w    = mul_rsp.hi[DATA_W:0];
   assign innov_w = {{(INNOV_W-DATA_W){sample_ff[DATA_W-1]}}, sample_ff}
                  - {{(INNOV_W-DATA_W-1){hx_w[DATA_W]}}, hx_w};
   assign corr_w  = {mul_rsp.hi[CORR_W-3:0], mul_rsp.lo[MPLIER_W-1 -: 2]};
   assign gh_w    = {mul_rsp.hi[GH_W-SCALE_W-1:0], mul_rsp.lo[MPLIER_W-1 -: SCALE_W]};

   // estimate update with saturation to signed 32 bits
   assign est_sum = {{5{est_ff[DATA_W-1]}}, est_ff}
                  + {corr_w[CORR_W-1], corr_w};
   always_comb begin
      if (est_sum[DATA_W+4:DATA_W-1] == '0 || est_sum[DATA_W+4:DATA_W-1] == '1) begin
         est_sat = est_sum[DATA_W-1:0];
      end else if (est_sum[DATA_W+4]) begin
         est_sat = EST_MIN;
      end else begin
         est_sat = EST_MAX;
      end
   end

   // covariance factor 1 - gain*h, clamped at zero
   assign fac_w = (gh_w[GH_W-1:DATA_W] != '0) ? '0
                : ({1'b1, {DATA_W{1'b0}}} - {1'b0, gh_w[DATA_W-1:0]});

   // sequencer: each product or quotient is launched on the cycle the previous one lands
   always_comb begin
      state_in    = state_ff;
      mul_req     = '0;
      div_req     = '0;
      sample_in   = sample_ff;
      prior_in    = prior_ff;
      innov_in    = innov_ff;
      hp_in       = hp_ff;
      gain_in     = gain_ff;
      est_in      = est_ff;
      cov_in      = cov_ff;
      rsp_data_in = rsp_data_ff;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               sample_in      = req_bus.sample;
               prior_in       = prior_sat;
               mul_req.start  = 1'b1;
               mul_req.mcand  = {{(MCAND_W-DATA_W){est_ff[DATA_W-1]}}, est_ff};
               mul_req.mplier = {{(MPLIER_W-SCALE_W){1'b0}}, measure_scale_ff};
               mul_req.nbits  = MUL_LEN_SCALE;
               state_in       = ST_MUL_HX;
            end
         end
         ST_MUL_HX: begin
            // h * estimate lands: form the innovation, start h * prior
            if (mul_rsp.done) begin
               innov_in       = innov_w;
               mul_req.start  = 1'b1;
               mul_req.mcand  = {{(MCAND_W-DATA_W){1'b0}}, prior_ff};
               mul_req.mplier = {{(MPLIER_W-SCALE_W){1'b0}}, measure_scale_ff};
               mul_req.nbits  = MUL_LEN_SCALE;
               state_in       = ST_MUL_HP;
            end
         end
         ST_MUL_HP: begin
            if (mul_rsp.done) begin
               hp_in          = hp_w;
               mul_req.start  = 1'b1;
               mul_req.mcand  = {{(MCAND_W-HP_W){1'b0}}, hp_w};
               mul_req.mplier = {{(MPLIER_W-SCALE_W){1'b0}}, measure_scale_ff};
               mul_req.nbits  = MUL_LEN_SCALE;
               state_in       = ST_MUL_HHP;
            end
         end
         ST_MUL_HHP: begin
            // denominator h*h*prior + R goes straight into the divider
            if (mul_rsp.done) begin
               div_req.start = 1'b1;
               div_req.hp    = hp_ff;
               div_req.den   = den_w;
               state_in      = ST_DIV_GAIN;
            end
         end
         ST_DIV_GAIN: begin
            if (div_rsp.done) begin
               gain_in        = div_rsp.gain;
               mul_req.start  = 1'b1;
               mul_req.mcand  = {{(MCAND_W-INNOV_W){innov_ff[INNOV_W-1]}}, innov_ff};
               mul_req.mplier = {{(MPLIER_W-GAIN_W){1'b0}}, div_rsp.gain};
               mul_req.nbits  = MUL_LEN_GAIN;
               state_in       = ST_MUL_CORR;
            end
         end
         ST_MUL_CORR: begin
            if (mul_rsp.done) begin
               est_in         = est_sat;
               mul_req.start  = 1'b1;
               mul_req.mcand  = {{(MCAND_W-GAIN_W){1'b0}}, gain_ff};
               mul_req.mplier = {{(MPLIER_W-SCALE_W){1'b0}}, measure_scale_ff};
               mul_req.nbits  = MUL_LEN_SCALE;
               state_in       = ST_MUL_GH;
            end
         end
         ST_MUL_GH: begin
            if (mul_rsp.done) begin
               mul_req.start  = 1'b1;
               mul_req.mcand  = {{(MCAND_W-FAC_W){1'b0}}, fac_w};
               mul_req.mplier = prior_ff;
               mul_req.nbits  = MUL_LEN_FULL;
               state_in       = ST_MUL_COV;
            end
         end
         ST_MUL_COV: begin
            // upper half of fac * prior is the new covariance
            if (mul_rsp.done) begin
               cov_in   = mul_rsp.hi[DATA_W-1:0];
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // wait only if the previous estimate has not been transferred yet
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_data_in = est_ff;
               rsp_load    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         est_ff           <= EST_VALUE_RST;
         cov_ff           <= EST_COV_RST;
         process_noise_ff <= PROCESS_NOISE_RST;
         measure_noise_ff <= MEASURE_NOISE_RST;
         measure_scale_ff <= MEASURE_SCALE_RST;
      end else begin
         state_ff <= state_in;
         est_ff   <= est_in;
         cov_ff   <= cov_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PROCESS_NOISE: process_noise_ff <= csr_wr_data;
               CSR_MEASURE_NOISE: measure_noise_ff <= csr_wr_data;
               CSR_MEASURE_SCALE: measure_scale_ff <= csr_wr_data[SCALE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      prior_ff    <= prior_in;
      innov_ff    <= innov_in;
      hp_ff       <= hp_in;
      gain_ff     <= gain_in;
      rsp_data_ff <= rsp_data_in;
   end

   // handshake
   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.estimate = rsp_data_ff;

   a_mul_no_restart: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_rsp.busy)
      else $error("product launched while the multiplier is still running");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESULT)
      else $error("output register loaded outside the result step");

   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mul_rsp.busy && !div_rsp.busy)
      else $error("arithmetic unit busy while waiting for a sample");

   a_cov_not_above_prior: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESULT |-> cov_ff <= prior_ff)
      else $error("updated covariance exceeds the prior covariance");

endmodule

@@ rtl/core/skf_serial_mul.sv @@
`timescale 1ns / 1ps

module skf_serial_mul import skf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  skf_mul_req_type mul_req,
   output skf_mul_rsp_type mul_rsp
);

   logic [ACC_HI_W-1:0]  hi_ff, hi_in;
   logic [MPLIER_W-1:0]  lo_ff, lo_in;
   logic [MPLIER_W-1:0]  mp_ff, mp_in;
   logic [MCAND_W-1:0]   mc_ff, mc_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [ACC_HI_W-1:0]  addend;
   logic [ACC_HI_W-1:0]  sum;

   // one multiplier bit per cycle, product bits shift out into lo
   assign addend = mp_ff[0] ? {mc_ff[MCAND_W-1], mc_ff} : '0;
   assign sum    = hi_ff + addend;

   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      mp_in   = mp_ff;
      mc_in   = mc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         hi_in   = '0;
         lo_in   = '0;
         mp_in   = mul_req.mplier;
         mc_in   = mul_req.mcand;
         cnt_in  = mul_req.nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = {sum[ACC_HI_W-1], sum[ACC_HI_W-1:1]};
         lo_in  = {sum[0], lo_ff[MPLIER_W-1:1]};
         mp_in  = {1'b0, mp_ff[MPLIER_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      mp_ff <= mp_in;
      mc_ff <= mc_in;
   end

   assign mul_rsp.busy = busy_ff;
   assign mul_rsp.done = done_ff;
   assign mul_rsp.hi   = hi_ff;
   assign mul_rsp.lo   = lo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("multiplier done without a running product");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("multiplier running with an empty bit count");

endmodule

@@ rtl/core/skf_serial_div.sv @@
`timescale 1ns / 1ps

module skf_serial_div import skf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  skf_div_req_type div_req,
   output skf_div_rsp_type div_rsp
);

   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [GAIN_W-1:0]    num_ff, num_in;     // low numerator bits, msb first
   logic [GAIN_W-1:0]    quo_ff, quo_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [HP_W-1:0]      hp_ff, hp_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_W:0]       trial;
   logic [REM_W:0]       diff;
   logic                 fits;
   logic                 den_zero;
   logic                 quo_sat;

   // numerator is hp * 2^16; the top part hp >> 2 seeds the remainder
   assign trial = {rem_ff, num_ff[GAIN_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      hp_in   = hp_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = {{(REM_W-HP_W+2){1'b0}}, div_req.hp[HP_W-1:2]};
         num_in  = {div_req.hp[1:0], {(GAIN_W-2){1'b0}}};
         quo_in  = '0;
         den_in  = div_req.den;
         hp_in   = div_req.hp;
         cnt_in  = DIV_CNT_W'(GAIN_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
         quo_in = {quo_ff[GAIN_W-2:0], fits};
         num_in = {num_ff[GAIN_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      hp_ff  <= hp_in;
   end

   // quotient reaches 2^18 exactly when hp >= 4 * den
   assign den_zero = (den_ff == '0);
   assign quo_sat  = {3'b000, hp_ff} >= {den_ff, 2'b00};

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.gain = den_zero ? '0 : (quo_sat ? '1 : quo_ff);

endmodule
